// ===== rtl/pru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler package
// Shared constants, register indexes, state type and the control and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pru_pkg;

    // Line store and scale limits
    localparam int MAX_WIDTH = 1024;
    localparam int MAX_SCALE = 16;

    // Field widths
    localparam int SCALE_W = 5;
    localparam int WIDTH_W = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int RCOL_W  = COL_W + 1;
    localparam int REP_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int PAD_W   = 2;
    localparam int PIX_W   = 24;

    // Configuration register indexes
    localparam logic REG_SCALE    = 1'b0;
    localparam logic REG_IN_WIDTH = 1'b1;

    // Operation codes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_PAD   = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic load_last;   // this load fills the last column
        logic px_phase;    // still sending pixels of the row
        logic rep_last;    // last copy of the current pixel
        logic col_last;    // current pixel is the last one of the row
        logic pad_zero;    // the row needs no padding bytes
        logic pad_last;    // this padding byte ends the row
        logic rows_last;   // this row ends the block
    } status_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic wr_pixel;    // write the loaded word to the line store
        logic load_inc;    // advance the load column
        logic drain_start; // clear all counters and begin a drain
        logic emit;        // read the store and send one word
        logic kind;        // pixel or padding word
        logic rep_inc;     // advance the copy count
        logic col_inc;     // move to the next stored pixel
        logic pad_inc;     // advance the padding count
        logic row_done;    // row complete: rewind the row counters
        logic row_inc;     // advance the row repeat count
        logic block_done;  // block complete: rewind the row repeat count and the load column
    } command_t;

endpackage

// ===== rtl/pru_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler controller
// Load/drain state machine; turns accepted words and datapath status into
// commands for the datapath.
// ----------------------------------------------------------------------------
module pru_ctrl import pru_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  logic     op,
    input  status_t  status,
    output command_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   load_word;
    logic   req_word;
    logic   row_end;

    assign load_word = accept && (op == OP_LOAD);
    assign req_word  = accept && (op == OP_REQUEST);

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Work out when a row ends
    always_comb
    begin
        row_end = 1'b0;
        if (status.px_phase)
        begin
            row_end = status.rep_last && status.col_last && status.pad_zero;
        end
        else
        begin
            row_end = status.pad_last;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (load_word && status.load_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (req_word && row_end && status.rows_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                // Store the pixel; requests while idle are dropped
                if (load_word)
                begin
                    cmd.wr_pixel = 1'b1;
                    if (status.load_last)
                    begin
                        cmd.drain_start = 1'b1;
                    end
                    else
                    begin
                        cmd.load_inc = 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                // Loads during a drain are dropped
                if (req_word)
                begin
                    cmd.emit = 1'b1;
                    if (status.px_phase)
                    begin
                        cmd.kind = KIND_PIXEL;
                        if (status.rep_last)
                        begin
                            cmd.col_inc = 1'b1;
                        end
                        else
                        begin
                            cmd.rep_inc = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.kind = KIND_PAD;
                        if (!status.pad_last)
                        begin
                            cmd.pad_inc = 1'b1;
                        end
                    end
                    if (row_end)
                    begin
                        cmd.row_done = 1'b1;
                        if (status.rows_last)
                        begin
                            cmd.block_done = 1'b1;
                        end
                        else
                        begin
                            cmd.row_inc = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/pru_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler datapath
// Configuration registers, line store, column and repeat counters, and the
// output word register.
// ----------------------------------------------------------------------------
module pru_datapath import pru_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [WIDTH_W-1:0] wr_data,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,
    input  command_t           cmd,
    output status_t            status,
    output logic               done,
    output logic               kind,
    output logic [7:0]         out_blue,
    output logic [7:0]         out_green,
    output logic [7:0]         out_red,
    output logic               row_end,
    output logic               block_end
);

    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [SCALE_W-1:0] eff_scale;
    logic [WIDTH_W-1:0] eff_width;
    logic [3:0]         pad_prod;
    logic [PAD_W-1:0]   pad_need;

    logic [COL_W-1:0]  load_col_reg;
    logic [RCOL_W-1:0] read_col_reg;
    logic [REP_W-1:0]  rep_reg;
    logic [PAD_W-1:0]  pad_reg;
    logic [REP_W-1:0]  row_reg;

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    logic done_reg;
    logic kind_reg;
    logic row_end_reg;
    logic block_end_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_W'(1);
            width_reg <= WIDTH_W'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SCALE:    scale_reg <= wr_data[SCALE_W-1:0];
                REG_IN_WIDTH: width_reg <= wr_data;
                default:      width_reg <= width_reg;
            endcase
        end
    end

    // Clamp the settings into range
    always_comb
    begin
        if (scale_reg == '0)
        begin
            eff_scale = SCALE_W'(1);
        end
        else if (scale_reg > SCALE_W'(MAX_SCALE))
        begin
            eff_scale = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            eff_scale = scale_reg;
        end

        if (width_reg == '0)
        begin
            eff_width = WIDTH_W'(1);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            eff_width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            eff_width = width_reg;
        end
    end

    // Padding bytes: 3*w*s bytes need (w*s) mod 4 more to reach a multiple of 4
    assign pad_prod = {2'b00, eff_width[1:0]} * {2'b00, eff_scale[1:0]};
    assign pad_need = pad_prod[PAD_W-1:0];

    // Status for the controller
    always_comb
    begin
        status.load_last = (WIDTH_W'(load_col_reg) + WIDTH_W'(1)) >= eff_width;
        status.px_phase  = WIDTH_W'(read_col_reg) < eff_width;
        status.rep_last  = (SCALE_W'(rep_reg) + SCALE_W'(1)) >= eff_scale;
        status.col_last  = (WIDTH_W'(read_col_reg) + WIDTH_W'(1)) >= eff_width;
        status.pad_zero  = pad_need == '0;
        status.pad_last  = ({1'b0, pad_reg} + 3'd1) >= {1'b0, pad_need};
        status.rows_last = (SCALE_W'(row_reg) + SCALE_W'(1)) >= eff_scale;
    end

    // Advance the counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_col_reg <= '0;
            read_col_reg <= '0;
            rep_reg      <= '0;
            pad_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            if (cmd.drain_start)
            begin
                load_col_reg <= '0;
                read_col_reg <= '0;
                rep_reg      <= '0;
                pad_reg      <= '0;
                row_reg      <= '0;
            end
            else if (cmd.load_inc)
            begin
                load_col_reg <= load_col_reg + COL_W'(1);
            end

            if (cmd.row_done)
            begin
                read_col_reg <= '0;
                rep_reg      <= '0;
                pad_reg      <= '0;
            end
            else
            begin
                if (cmd.col_inc)
                begin
                    read_col_reg <= read_col_reg + RCOL_W'(1);
                    rep_reg      <= '0;
                end
                else if (cmd.rep_inc)
                begin
                    rep_reg <= rep_reg + REP_W'(1);
                end
                if (cmd.pad_inc)
                begin
                    pad_reg <= pad_reg + PAD_W'(1);
                end
            end

            if (cmd.block_done)
            begin
                row_reg      <= '0;
                load_col_reg <= '0;
            end
            else if (cmd.row_inc)
            begin
                row_reg <= row_reg + REP_W'(1);
            end
        end
    end

    // Line store: write on load, registered read on request
    always_ff @(posedge clk)
    begin
        if (cmd.wr_pixel)
        begin
            line_mem[load_col_reg] <= {red, green, blue};
        end
        if (cmd.emit)
        begin
            rd_data_reg <= line_mem[read_col_reg[COL_W-1:0]];
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= 1'b0;
            kind_reg      <= KIND_PIXEL;
            row_end_reg   <= 1'b0;
            block_end_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= cmd.emit;
            kind_reg      <= cmd.emit && (cmd.kind == KIND_PAD);
            row_end_reg   <= cmd.emit && cmd.row_done;
            block_end_reg <= cmd.emit && cmd.block_done;
        end
    end

    // Drive the result; padding words carry zero bytes
    assign done      = done_reg;
    assign kind      = kind_reg;
    assign row_end   = row_end_reg;
    assign block_end = block_end_reg;
    assign out_blue  = (kind_reg == KIND_PAD) ? 8'h00 : rd_data_reg[7:0];
    assign out_green = (kind_reg == KIND_PAD) ? 8'h00 : rd_data_reg[15:8];
    assign out_red   = (kind_reg == KIND_PAD) ? 8'h00 : rd_data_reg[23:16];

endmodule

// ===== rtl/pixel_replicate_upscaler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler
// Nearest-neighbour integer upscale of 24-bit pixel rows with row padding.
// Results: a request word gives its result on done in the cycle after it is
//   taken, through the registered read of the line store.
// Throughput: one word per cycle; busy stays low, so start is always taken.
// Reset: counters clear, scale and width return to 1, the block is idle;
//   the line store is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler_unit import pru_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic               wr_index,
    input  logic [WIDTH_W-1:0] wr_data,
    input  logic               start,
    output logic               busy,
    input  logic               op,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,
    output logic               done,
    output logic               kind,
    output logic [7:0]         out_blue,
    output logic [7:0]         out_green,
    output logic [7:0]         out_red,
    output logic               row_end,
    output logic               block_end
);

    status_t  status;
    command_t cmd;
    logic     accept;

    // Busy is tied low, so every word is taken when it is offered
    assign busy   = 1'b0;
    assign accept = start && !busy;

    pru_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .op     (op),
        .status (status),
        .cmd    (cmd)
    );

    pru_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .cmd       (cmd),
        .status    (status),
        .done      (done),
        .kind      (kind),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .row_end   (row_end),
        .block_end (block_end)
    );

    // A result only follows an accepted request
    a_done_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && (op == OP_REQUEST)))
        else $error("result without a preceding request");

    // The end of a block is always the end of a row
    a_block_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        block_end |-> (row_end && done))
        else $error("block end without row end");

    // Row markers only travel with a result
    a_row_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        row_end |-> done)
        else $error("row end without a result");

    // Padding words carry zero bytes
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (kind == KIND_PAD)) |->
            (out_blue == 8'h00 && out_green == 8'h00 && out_red == 8'h00))
        else $error("padding word with non-zero bytes");

endmodule

// ===== tb/sv/tb_pixel_replicate_upscaler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel replicate upscaler testbench
// Drives load and request words into the upscaler and keeps a cycle-free
// model of the line store, the copy, padding and row repeat counters. Every
// output word is checked field by field against the oldest prediction. A short
// directed table comes first, then random rows of pixels with noise words and
// broken rows mixed in, and finally the largest scale on a single pixel.
// ----------------------------------------------------------------------------
module tb_pixel_replicate_upscaler_unit;
    import pru_pkg::*;

    localparam int RANDOM_WORDS = 1000;
    localparam int DIR_ROWS     = 30;
    localparam int DIR_WORDS    = 25;
    localparam int SHOW_LIMIT   = 50;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       row_end;
        logic       block_end;
    } upscale_word_t;

    typedef enum logic {
        ACT_WORD,
        ACT_REG
    } dir_act_t;

    // One directed step: a word (sel is the operation) or a register write
    typedef struct packed {
        dir_act_t           act;
        logic               sel;
        logic [WIDTH_W-1:0] data;
        logic [7:0]         b;
        logic [7:0]         g;
        logic [7:0]         r;
        logic               typed;
        logic               has_res;
        upscale_word_t      res;
    } dir_row_t;

    localparam upscale_word_t NO_WORD = '0;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // reset setting, one pixel per row, one copy
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, NO_WORD},
        '{ACT_WORD, OP_LOAD,    11'd0, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, NO_WORD},
        '{ACT_WORD, OP_LOAD,    11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
          '{KIND_PIXEL, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0}},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
          '{KIND_PAD, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, NO_WORD},
        // zero scale and zero width both act as one
        '{ACT_REG,  REG_SCALE,    11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_REG,  REG_IN_WIDTH, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_LOAD,    11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
          '{KIND_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
          '{KIND_PAD, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
        // two pixels, two padding bytes
        '{ACT_REG,  REG_SCALE,    11'd1, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_REG,  REG_IN_WIDTH, 11'd2, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_LOAD,    11'd0, 8'h12, 8'h34, 8'h56, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_LOAD,    11'd0, 8'hab, 8'hcd, 8'hef, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        // doubled: rows need no padding, two output rows
        '{ACT_REG,  REG_SCALE,    11'd2, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_LOAD,    11'd0, 8'h5a, 8'ha5, 8'h3c, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_LOAD,    11'd0, 8'hc3, 8'h0f, 8'hf0, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD},
        '{ACT_WORD, OP_REQUEST, 11'd0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, NO_WORD}
    };

    logic               clk;
    logic               rst_n;
    logic               wr_en;
    logic               wr_index;
    logic [WIDTH_W-1:0] wr_data;
    logic               start;
    logic               busy;
    logic               op;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic               done;
    logic               kind;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
    logic               row_end;
    logic               block_end;

    // Model state: line store, counters and register shadows
    logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
    int unsigned        ld_col;
    int unsigned        rd_col;
    int unsigned        copy_cnt;
    int unsigned        pad_cnt;
    int unsigned        rows_done;
    bit                 in_drain;
    logic [SCALE_W-1:0] cfg_scale;
    logic [WIDTH_W-1:0] cfg_width;

    upscale_word_t      expected_words [$];
    int unsigned        words_sent;
    int unsigned        words_checked;
    int unsigned        blocks_seen;
    int unsigned        reg_writes;
    int unsigned        mismatches;

    pixel_replicate_upscaler_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .done      (done),
        .kind      (kind),
        .out_blue  (out_blue),
        .out_green (out_green),
        .out_red   (out_red),
        .row_end   (row_end),
        .block_end (block_end)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Clamp the register shadows to their working range
    function automatic int unsigned active_scale();
        int unsigned v;
        v = 32'(cfg_scale);
        if (v == 0) return 1;
        if (v > MAX_SCALE) return MAX_SCALE;
        return v;
    endfunction

    function automatic int unsigned active_width();
        int unsigned v;
        v = 32'(cfg_width);
        if (v == 0) return 1;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return v;
    endfunction

    // Advance the model by one accepted word; return 1 when it gives an output word
    function automatic bit predict_upscale(input logic word_op, input logic [7:0] pb,
                                           input logic [7:0] pg, input logic [7:0] pr,
                                           output upscale_word_t res);
        int unsigned      w;
        int unsigned      s;
        int unsigned      pad;
        logic [PIX_W-1:0] px;
        w   = active_width();
        s   = active_scale();
        pad = (4 - ((w * s * 3) & 3)) & 3;
        res = NO_WORD;

        // loads fill the store and start the drain on the last column
        if (word_op == OP_LOAD) begin
            if (in_drain) return 1'b0;
            if (ld_col < MAX_WIDTH) line_mem[COL_W'(ld_col)] = {pr, pg, pb};
            if (ld_col + 1 >= w) begin
                in_drain  = 1'b1;
                ld_col    = 0;
                rd_col    = 0;
                copy_cnt  = 0;
                pad_cnt   = 0;
                rows_done = 0;
            end
            else begin
                ld_col++;
            end
            return 1'b0;
        end

        if (!in_drain) return 1'b0;

        // pixel phase, then padding phase
        if (rd_col < w) begin
            px            = line_mem[COL_W'(rd_col)];
            res.kind      = KIND_PIXEL;
            res.out_blue  = px[7:0];
            res.out_green = px[15:8];
            res.out_red   = px[23:16];
            if (copy_cnt + 1 >= s) begin
                copy_cnt = 0;
                rd_col++;
                if (rd_col >= w && pad == 0) res.row_end = 1'b1;
            end
            else begin
                copy_cnt++;
            end
        end
        else begin
            res.kind = KIND_PAD;
            if (pad_cnt + 1 >= pad) res.row_end = 1'b1;
            else pad_cnt++;
        end

        // rewind at the end of a row, return to idle at the end of the block
        if (res.row_end) begin
            rd_col   = 0;
            copy_cnt = 0;
            pad_cnt  = 0;
            if (rows_done + 1 >= s) begin
                res.block_end = 1'b1;
                rows_done     = 0;
                in_drain      = 1'b0;
                ld_col        = 0;
            end
            else begin
                rows_done++;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("[%0t] mismatch at output word %0d: %s", $realtime, words_checked, what);
    endtask

    // Offer one word, hold it until taken, then log its prediction
    task automatic send_word(input logic word_op, input logic [7:0] pb, input logic [7:0] pg,
                             input logic [7:0] pr, input bit typed, input bit typed_has,
                             input upscale_word_t typed_res);
        upscale_word_t res;
        bit            has;
        bit            calm;
        calm = (words_sent >= 400 && words_sent < 750);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            op    <= 1'($urandom);
            blue  <= 8'($urandom);
            @(negedge clk);
        end
        start <= 1'b1;
        op    <= word_op;
        blue  <= pb;
        green <= pg;
        red   <= pr;
        @(posedge clk);
        while (busy) @(posedge clk);
        has = predict_upscale(word_op, pb, pg, pr, res);
        if (typed) begin
            has = typed_has;
            res = typed_res;
        end
        if (has) expected_words.push_back(res);
        words_sent++;
    endtask

    // Write a register once the block has gone quiet
    task automatic write_reg(input logic idx, input logic [WIDTH_W-1:0] value);
        @(negedge clk) start <= 1'b0;
        wait (expected_words.size() == 0);
        repeat (3) @(posedge clk);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        if (idx == REG_SCALE) cfg_scale = value[SCALE_W-1:0];
        else cfg_width = value;
        reg_writes++;
        @(negedge clk) wr_en <= 1'b0;
    endtask

    // Load one row and drain its block, with stray words mixed in; may_break can cut the row short
    task automatic run_row_block(input bit may_break);
        int unsigned stop_after;
        int unsigned loaded;
        stop_after = 0;
        loaded     = 0;
        if (may_break && $urandom_range(0, 9) == 0) stop_after = $urandom_range(1, active_width());
        while (!in_drain) begin
            if ($urandom_range(0, 19) == 0) begin
                send_word(OP_REQUEST, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'b0, 1'b0, NO_WORD);
            end
            else begin
                send_word(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'b0, 1'b0, NO_WORD);
                loaded++;
                // drop the rest of the row: the next block carries on loading it
                if (stop_after != 0 && loaded >= stop_after && !in_drain) return;
            end
        end
        while (in_drain) begin
            if ($urandom_range(0, 19) == 0)
                send_word(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'b0, 1'b0, NO_WORD);
            else
                send_word(OP_REQUEST, 8'($urandom), 8'($urandom), 8'($urandom),
                          1'b0, 1'b0, NO_WORD);
        end
    endtask

    // Check each output word against the oldest prediction
    always @(posedge clk)
    begin
        upscale_word_t want;
        if (rst_n && done === 1'b1) begin
            if (expected_words.size() == 0) begin
                report_mismatch("output word with nothing expected");
            end
            else begin
                want = expected_words.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                if (out_blue !== want.out_blue)
                    report_mismatch($sformatf("blue %h, want %h", out_blue, want.out_blue));
                if (out_green !== want.out_green)
                    report_mismatch($sformatf("green %h, want %h", out_green, want.out_green));
                if (out_red !== want.out_red)
                    report_mismatch($sformatf("red %h, want %h", out_red, want.out_red));
                if (row_end !== want.row_end)
                    report_mismatch($sformatf("row_end %0d, want %0d", row_end, want.row_end));
                if (block_end !== want.block_end)
                    report_mismatch($sformatf("block_end %0d, want %0d",
                                              block_end, want.block_end));
                if (want.block_end) blocks_seen++;
                words_checked++;
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [WIDTH_W-1:0] next_scale;
        logic [WIDTH_W-1:0] next_width;

        rst_n         = 1'b0;
        wr_en         = 1'b0;
        wr_index      = REG_SCALE;
        wr_data       = '0;
        start         = 1'b0;
        op            = OP_LOAD;
        blue          = 8'h00;
        green         = 8'h00;
        red           = 8'h00;
        ld_col        = 0;
        rd_col        = 0;
        copy_cnt      = 0;
        pad_cnt       = 0;
        rows_done     = 0;
        in_drain      = 1'b0;
        cfg_scale     = 1;
        cfg_width     = 1;
        words_sent    = 0;
        words_checked = 0;
        blocks_seen   = 0;
        reg_writes    = 0;
        mismatches    = 0;

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // walk the directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].act == ACT_REG)
                write_reg(DIR_TABLE[i].sel, DIR_TABLE[i].data);
            else
                send_word(DIR_TABLE[i].sel, DIR_TABLE[i].b, DIR_TABLE[i].g, DIR_TABLE[i].r,
                          DIR_TABLE[i].typed, DIR_TABLE[i].has_res, DIR_TABLE[i].res);
        end

        // random rows; reconfigure only while no row is part loaded
        while (words_sent < DIR_WORDS + RANDOM_WORDS) begin
            if (ld_col == 0 && $urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 4) == 0) begin
                    next_scale = WIDTH_W'($urandom_range(5, 31));
                    next_width = WIDTH_W'($urandom_range(0, 3));
                end
                else begin
                    next_scale = WIDTH_W'($urandom_range(0, 4));
                    next_width = WIDTH_W'($urandom_range(0, 12));
                end
                if ($urandom_range(0, 3) != 0) write_reg(REG_SCALE, next_scale);
                if ($urandom_range(0, 3) != 0) write_reg(REG_IN_WIDTH, next_width);
            end
            run_row_block(1'b1);
        end
        if (ld_col != 0) run_row_block(1'b0);

        // largest scale on one pixel
        write_reg(REG_SCALE, 11'd31);
        write_reg(REG_IN_WIDTH, 11'd1);
        run_row_block(1'b0);

        // drain and settle
        @(negedge clk) start <= 1'b0;
        wait (expected_words.size() == 0);
        repeat (4) @(posedge clk);

        $display("Sent %0d words, checked %0d output words over %0d completed blocks,",
                 words_sent, words_checked, blocks_seen);
        $display("with %0d register writes and %0d mismatches.", reg_writes, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
